[hw/rtl/dds_setup_word_sequencer_macros.svh]
// Assertion macros for the set-up word sequencer.
`ifndef DDS_SETUP_WORD_SEQUENCER_MACROS_SVH
`define DDS_SETUP_WORD_SEQUENCER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define DSWS_CHECK_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dsws check failed");
// next-cycle implication
`define DSWS_CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dsws check failed");
`else
`define DSWS_CHECK_NOW(label, clk, rst, ante, cons)
`define DSWS_CHECK_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/dsws_pkg.sv]
`default_nettype none
package dsws_pkg;

   // tuning word = floor(freq * FTW_SCALE / FTW_DIVISOR)
   localparam logic [23:0] FTW_SCALE   = 24'd10737418;
   localparam logic [23:0] FTW_DIVISOR = 24'd10000000;
   // floor(FTW_SCALE * 2^28 / FTW_DIVISOR); estimate is exact or one low
   localparam int          RECIP_SHIFT = 28;
   localparam logic [28:0] FTW_RECIP   =
      29'((64'(FTW_SCALE) << RECIP_SHIFT) / 64'(FTW_DIVISOR));

   localparam logic [15:0] WORD_RESET  = 16'h0100;
   localparam logic [15:0] WORD_B28    = 16'h2100;
   localparam logic [15:0] TAG_FREQ0   = 16'h4000;
   localparam logic [15:0] TAG_FREQ1   = 16'h8000;
   localparam logic [15:0] TAG_PHASE0  = 16'hC000;
   localparam logic [15:0] CTRL_SINE   = 16'h2000;
   localparam logic [15:0] CTRL_TRI    = 16'h2002;
   localparam logic [15:0] CTRL_SQUARE = 16'h2028;
   localparam logic [15:0] CTRL_FSEL   = 16'h0800;

   localparam logic [1:0] SHAPE_SINE   = 2'd0;
   localparam logic [1:0] SHAPE_TRI    = 2'd1;
   localparam logic [1:0] SHAPE_SQUARE = 2'd2;

   typedef struct packed {
      logic [26:0] frequency_decihertz;
      logic        freq_register;
      logic [1:0]  wave_shape;
      logic [11:0] phase_word;
      logic        target_channel;
      logic        action;
   } req_type;

   typedef struct packed {
      logic [15:0] command_word;
      logic        dest_channel;
      logic        last_word;
   } rsp_type;

   // request fields that ride along with the tuning word math
   typedef struct packed {
      logic        freq_register;
      logic [1:0]  wave_shape;
      logic [11:0] phase_word;
      logic        target_channel;
      logic        action;
   } req_meta_type;

   typedef struct packed {
      logic [27:0]  ftw;
      req_meta_type meta;
   } ftw_item_type;

   // handshake between the tuning word pipe and the word sequencer
   typedef struct packed {
      logic         valid;
      ftw_item_type item;
   } ftw_link_type;

endpackage
`default_nettype wire

[hw/rtl/dds_setup_word_sequencer.sv]
// A request passes the three tuning word stages, sequencer state and output register.
// Throughput: one command word per cycle while rsp_stall is low; a request holds the
// word sequencer for 6 command words (single), 11 (dual), 5 or 9 when the shape code has no control word.
// The three-stage tuning word pipe takes a request every cycle while req_stall is low
// and holds up to three; with the one in the sequencer, four requests can be in flight.
// Reset: synchronous, active high; clears valid bits and sequencer state only.
`default_nettype none
module dds_setup_word_sequencer
   import dsws_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   // Tuning word: floor(freq * 10737418 / 10^7) from a reciprocal estimate
   // (freq * floor(2^28 * scale / divisor)) >> 28, which is exact or one low.
   // The remainder check in the last pipe stage adds the missing one.
   ftw_link_type ftw_link;
   logic         ftw_stall;

   dsws_ftw_pipe u_ftw_pipe (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_link  (ftw_link),
      .out_stall (ftw_stall)
   );

   // Word sequencer: walks the single or dual step list, one word per cycle while
   // rsp_stall is low, through an output register. It takes the next request in the same
   // cycle its last word goes out, so sequences run back to back.
   dsws_word_seq u_word_seq (
      .clock     (clock),
      .reset     (reset),
      .in_link   (ftw_link),
      .in_stall  (ftw_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

[hw/rtl/dsws_ftw_pipe.sv]
`default_nettype none
`include "dds_setup_word_sequencer_macros.svh"
module dsws_ftw_pipe
   import dsws_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_type      req_data,
   output ftw_link_type      out_link,
   input  wire logic         out_stall
);

   localparam logic [25:0] DIV26    = 26'(FTW_DIVISOR);
   localparam logic [25:0] DIV26_X2 = 26'(2 * FTW_DIVISOR);

   // stage 1: reciprocal estimate and low bits of the exact product
   logic         v1_ff, v1_in;
   logic [27:0]  q0_1_ff;
   logic [25:0]  plow_1_ff;
   req_meta_type meta_1_ff;
   // stage 2: estimate times divisor, low bits
   logic         v2_ff, v2_in;
   logic [27:0]  q0_2_ff;
   logic [25:0]  plow_2_ff;
   logic [25:0]  qd_2_ff;
   req_meta_type meta_2_ff;
   // stage 3: corrected quotient
   logic         v3_ff, v3_in;
   ftw_item_type item_3_ff;

   logic        ld1, ld2, ld3;
   logic [55:0] est_prod;
   logic [25:0] rem;
   req_meta_type req_meta;

   assign ld3 = !v3_ff || !out_stall;
   assign ld2 = !v2_ff || ld3;
   assign ld1 = !v1_ff || ld2;
   assign req_stall = !ld1;

   assign est_prod = 56'(req_data.frequency_decihertz) * 56'(FTW_RECIP);
   assign rem      = plow_2_ff - qd_2_ff;

   assign req_meta.freq_register  = req_data.freq_register;
   assign req_meta.wave_shape     = req_data.wave_shape;
   assign req_meta.phase_word     = req_data.phase_word;
   assign req_meta.target_channel = req_data.target_channel;
   assign req_meta.action         = req_data.action;

   always_comb begin
      v1_in = ld1 ? req_valid : v1_ff;
      v2_in = ld2 ? v1_ff : v2_ff;
      v3_in = ld3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         q0_1_ff   <= est_prod[55:28];
         plow_1_ff <= 26'(req_data.frequency_decihertz) * 26'(FTW_SCALE);
         meta_1_ff <= req_meta;
      end
      if (ld2) begin
         q0_2_ff   <= q0_1_ff;
         plow_2_ff <= plow_1_ff;
         qd_2_ff   <= 26'(q0_1_ff) * DIV26;
         meta_2_ff <= meta_1_ff;
      end
      if (ld3) begin
         item_3_ff.ftw  <= q0_2_ff + 28'(rem >= DIV26);
         item_3_ff.meta <= meta_2_ff;
      end
   end

   assign out_link.valid = v3_ff;
   assign out_link.item  = item_3_ff;

   // estimate is never more than one below the true quotient
   `DSWS_CHECK_NOW(rem_in_range, clock, reset, v2_ff, rem < DIV26_X2)
   `DSWS_CHECK_NOW(stall_only_when_full, clock, reset, req_stall, v1_ff && v2_ff && v3_ff)
   `DSWS_CHECK_NEXT(held_item_stays, clock, reset, v3_ff && out_stall,
      v3_ff && $stable(item_3_ff))

endmodule
`default_nettype wire

[hw/rtl/dsws_word_seq.sv]
`default_nettype none
`include "dds_setup_word_sequencer_macros.svh"
module dsws_word_seq
   import dsws_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ftw_link_type in_link,
   output logic              in_stall,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_type           rsp_data
);

   typedef enum logic [2:0] {
      WK_RESET, WK_B28, WK_LSB, WK_MSB, WK_PHASE, WK_CTRL
   } word_kind_type;

   localparam word_kind_type SINGLE_KIND [6] = '{
      WK_RESET, WK_B28, WK_LSB, WK_MSB, WK_PHASE, WK_CTRL};
   localparam word_kind_type DUAL_KIND [11] = '{
      WK_RESET, WK_B28, WK_RESET, WK_B28, WK_LSB, WK_MSB,
      WK_PHASE, WK_LSB, WK_MSB, WK_CTRL, WK_CTRL};
   // chip select per dual-mode step, bit i for step i
   localparam logic [10:0] DUAL_CHAN = 11'b101_1100_1100;

   localparam logic [3:0] SINGLE_LAST         = 4'd5;
   localparam logic [3:0] SINGLE_LAST_NO_CTRL = 4'd4;
   localparam logic [3:0] DUAL_LAST           = 4'd10;
   localparam logic [3:0] DUAL_LAST_NO_CTRL   = 4'd8;

   logic        busy_ff, busy_in;
   logic [3:0]  step_ff, step_in;
   logic [15:0] lsb_w_ff, msb_w_ff, phs_w_ff, ctrl_w_ff;
   logic        has_ctrl_ff, chan_ff, dual_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;

   logic          out_take, emit, done, in_take;
   word_kind_type kind;
   rsp_type       cur;
   logic [15:0]   tag, ctrl_base;
   logic          shape_ok;

   // word images built as the request is taken in
   always_comb begin
      tag = in_link.item.meta.freq_register ? TAG_FREQ1 : TAG_FREQ0;
      shape_ok = 1'b1;
      case (in_link.item.meta.wave_shape)
         SHAPE_SINE:   ctrl_base = CTRL_SINE;
         SHAPE_TRI:    ctrl_base = CTRL_TRI;
         SHAPE_SQUARE: ctrl_base = CTRL_SQUARE;
         default: begin
            ctrl_base = CTRL_SINE;
            shape_ok  = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (dual_ff) begin
         kind             = DUAL_KIND[step_ff];
         cur.dest_channel = DUAL_CHAN[step_ff];
         cur.last_word    = has_ctrl_ff ? (step_ff == DUAL_LAST)
                                        : (step_ff == DUAL_LAST_NO_CTRL);
      end else begin
         kind             = SINGLE_KIND[step_ff[2:0]];
         cur.dest_channel = chan_ff;
         cur.last_word    = has_ctrl_ff ? (step_ff == SINGLE_LAST)
                                        : (step_ff == SINGLE_LAST_NO_CTRL);
      end
      case (kind)
         WK_RESET: cur.command_word = WORD_RESET;
         WK_B28:   cur.command_word = WORD_B28;
         WK_LSB:   cur.command_word = lsb_w_ff;
         WK_MSB:   cur.command_word = msb_w_ff;
         WK_PHASE: cur.command_word = phs_w_ff;
         WK_CTRL:  cur.command_word = ctrl_w_ff;
         default:  cur.command_word = WORD_RESET;
      endcase
   end

   assign out_take = !rsp_valid_ff || !rsp_stall;
   assign emit     = busy_ff && out_take;
   assign done     = emit && cur.last_word;
   assign in_stall = busy_ff && !done;
   assign in_take  = in_link.valid && !in_stall;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (in_take) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (emit) begin
         step_in = step_ff + 4'd1;
      end
      rsp_valid_in = out_take ? emit : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         lsb_w_ff    <= tag | {2'b00, in_link.item.ftw[13:0]};
         msb_w_ff    <= tag | {2'b00, in_link.item.ftw[27:14]};
         phs_w_ff    <= TAG_PHASE0 | {4'h0, in_link.item.meta.phase_word};
         ctrl_w_ff   <= ctrl_base | (in_link.item.meta.freq_register ? CTRL_FSEL : 16'h0000);
         has_ctrl_ff <= shape_ok;
         chan_ff     <= in_link.item.meta.target_channel;
         dual_ff     <= in_link.item.meta.action;
      end
      if (emit) begin
         rsp_data_ff <= cur;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `DSWS_CHECK_NOW(step_in_range, clock, reset, busy_ff,
      (dual_ff && step_ff <= DUAL_LAST) || (!dual_ff && step_ff <= SINGLE_LAST))
   `DSWS_CHECK_NEXT(take_starts_at_zero, clock, reset, in_take, busy_ff && step_ff == 4'd0)
   `DSWS_CHECK_NEXT(done_sends_last, clock, reset, done, rsp_valid_ff && rsp_data_ff.last_word)

endmodule
`default_nettype wire

[tb/dds_setup_word_sequencer_tb.sv]
`default_nettype none
module dds_setup_word_sequencer_tb
   import dsws_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // shape code with no control word behind it
   localparam logic [1:0] SHAPE_NONE = 2'd3;
   // request action codes
   localparam logic ACT_SINGLE = 1'b0;
   localparam logic ACT_DUAL   = 1'b1;
   // chip selects
   localparam logic CHAN0 = 1'b0;
   localparam logic CHAN1 = 1'b1;

   // number of result words after which the receiver takes its one long break
   localparam int unsigned LONG_HOLD_AT     = 240;
   localparam int unsigned LONG_HOLD_CYCLES = 160;
   localparam int unsigned RANDOM_REQUESTS  = 120;
   localparam int unsigned MAX_REPORTS      = 10;

   // one queued request plus how the sender should present it
   typedef struct {
      req_type     data;
      int unsigned idle_before;  // idle cycles before valid goes up
      bit          drain_first;  // hold until every owed word has arrived
   } pending_request_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   pending_request_type pending_requests[$];
   rsp_type             expected_words[$];

   int unsigned mismatches     = 0;
   int unsigned words_checked  = 0;
   int unsigned requests_taken = 0;
   int unsigned dual_taken     = 0;
   int unsigned no_ctrl_taken  = 0;

   dds_setup_word_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Word sequence predictor
   // ---------------------------------------------------------------------
   function automatic rsp_type cmd(input logic [15:0] word, input logic chan);
      rsp_type w;
      w.command_word = word;
      w.dest_channel = chan;
      w.last_word    = 1'b0;
      return w;
   endfunction

   // Builds the command words one request turns into, in order.
   function automatic void build_setup_words(input req_type r, output rsp_type words[$]);
      logic [63:0] product;
      logic [27:0] tuning;
      logic [15:0] tag;
      logic [15:0] lsb_word;
      logic [15:0] msb_word;
      logic [15:0] phase_cmd;
      logic [15:0] ctrl_word;
      logic        has_ctrl;
      rsp_type     tail;
      // exact product, then floor divide; only 28 bits of the tuning word go out
      product   = 64'(r.frequency_decihertz) * 64'(FTW_SCALE);
      product   = product / 64'(FTW_DIVISOR);
      tuning    = product[27:0];
      tag       = r.freq_register ? TAG_FREQ1 : TAG_FREQ0;
      lsb_word  = tag | {2'b00, tuning[13:0]};
      msb_word  = tag | {2'b00, tuning[27:14]};
      phase_cmd = TAG_PHASE0 | {4'h0, r.phase_word};
      has_ctrl  = 1'b1;
      case (r.wave_shape)
         SHAPE_SINE:   ctrl_word = CTRL_SINE;
         SHAPE_TRI:    ctrl_word = CTRL_TRI;
         SHAPE_SQUARE: ctrl_word = CTRL_SQUARE;
         default: begin
            ctrl_word = CTRL_SINE;
            has_ctrl  = 1'b0;
         end
      endcase
      if (r.freq_register)
         ctrl_word = ctrl_word | CTRL_FSEL;
      words = {};
      if (r.action == ACT_SINGLE) begin
         words.push_back(cmd(WORD_RESET, r.target_channel));
         words.push_back(cmd(WORD_B28, r.target_channel));
         words.push_back(cmd(lsb_word, r.target_channel));
         words.push_back(cmd(msb_word, r.target_channel));
         words.push_back(cmd(phase_cmd, r.target_channel));
         if (has_ctrl)
            words.push_back(cmd(ctrl_word, r.target_channel));
      end else begin
         // both chips: resets first, phase only to chip 1
         words.push_back(cmd(WORD_RESET, CHAN0));
         words.push_back(cmd(WORD_B28, CHAN0));
         words.push_back(cmd(WORD_RESET, CHAN1));
         words.push_back(cmd(WORD_B28, CHAN1));
         words.push_back(cmd(lsb_word, CHAN0));
         words.push_back(cmd(msb_word, CHAN0));
         words.push_back(cmd(phase_cmd, CHAN1));
         words.push_back(cmd(lsb_word, CHAN1));
         words.push_back(cmd(msb_word, CHAN1));
         if (has_ctrl) begin
            words.push_back(cmd(ctrl_word, CHAN0));
            words.push_back(cmd(ctrl_word, CHAN1));
         end
      end
      tail           = words.pop_back();
      tail.last_word = 1'b1;
      words.push_back(tail);
   endfunction

   function automatic req_type make_request(input logic [26:0] freq, input logic fsel,
                                            input logic [1:0] shape, input logic [11:0] phase,
                                            input logic chan, input logic act);
      req_type r;
      r.frequency_decihertz = freq;
      r.freq_register       = fsel;
      r.wave_shape          = shape;
      r.phase_word          = phase;
      r.target_channel      = chan;
      r.action              = act;
      return r;
   endfunction

   task automatic queue_request(input req_type r, input int unsigned idle, input bit drain);
      pending_request_type p;
      p.data        = r;
      p.idle_before = idle;
      p.drain_first = drain;
      pending_requests.push_back(p);
   endtask

   // mostly back to back, some short gaps, a few long ones
   function automatic int unsigned pick_sender_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 4);
      else
         return $urandom_range(15, 60);
   endfunction

   function automatic req_type random_request();
      req_type     r;
      int unsigned roll;
      r = req_type'(44'({$urandom, $urandom}));
      roll = $urandom_range(0, 99);
      // frequency: mostly in range, some small, some anywhere in 27 bits
      if (roll < 70)
         r.frequency_decihertz = 27'($urandom_range(0, 125000000));
      else if (roll < 85)
         r.frequency_decihertz = 27'($urandom_range(0, 20000));
      else
         r.frequency_decihertz = 27'($urandom);
      // unused shape code a bit less often than the real ones
      r.wave_shape = ($urandom_range(0, 9) == 0) ? SHAPE_NONE : 2'($urandom_range(0, 2));
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: feeds pending_requests, honors per-request idle
   // cycles and the drain hold. Keeps its own count of owed words from
   // sampled handshakes so it needs nothing from the monitor.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : request_driver
      int unsigned         idle_count;
      int                  words_owed;
      rsp_type             owed[$];
      pending_request_type head;
      logic                fire;
      logic                offer;
      if (reset) begin
         req_valid  <= 1'b0;
         idle_count = 0;
         words_owed = 0;
      end else begin
         fire = req_valid && !req_stall;
         if (fire) begin
            build_setup_words(req_data, owed);
            words_owed = words_owed + owed.size();
         end
         if (rsp_valid && !rsp_stall)
            words_owed = words_owed - 1;
         // a stalled request stays put; otherwise decide what goes out next
         if (!req_valid || fire) begin
            offer = 1'b0;
            if (pending_requests.size() != 0) begin
               head = pending_requests[0];
               if (idle_count >= head.idle_before && !(head.drain_first && words_owed != 0))
                  offer = 1'b1;
            end
            if (offer) begin
               void'(pending_requests.pop_front());
               req_data   <= head.data;
               idle_count = 0;
            end else begin
               idle_count = idle_count + 1;
            end
            req_valid <= offer;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver stall: random short and long holds, calm stretches, and one
   // long hold-off after LONG_HOLD_AT words so the pipe backs up.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : result_stall
      int unsigned words_taken;
      int unsigned hold_left;
      int unsigned stall_left;
      int unsigned cycle_count;
      bit          long_hold_done;
      bit          calm;
      int unsigned roll;
      if (reset) begin
         rsp_stall      <= 1'b0;
         words_taken    = 0;
         hold_left      = 0;
         stall_left     = 0;
         cycle_count    = 0;
         long_hold_done = 1'b0;
         calm           = 1'b0;
      end else begin
         cycle_count = cycle_count + 1;
         if (cycle_count % 128 == 0)
            calm = ($urandom_range(0, 3) == 0);
         if (rsp_valid && !rsp_stall)
            words_taken = words_taken + 1;
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (!long_hold_done && words_taken >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD_CYCLES - 1;
            rsp_stall      <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            rsp_stall  <= 1'b1;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
               rsp_stall <= 1'b0;
            end else if (roll < 95) begin
               stall_left = $urandom_range(0, 2);
               rsp_stall  <= 1'b1;
            end else begin
               stall_left = $urandom_range(10, 40);
               rsp_stall  <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks each result word against the oldest expectation,
   // then queues the words of any request accepted at this edge.
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatches = mismatches + 1;
      if (mismatches <= MAX_REPORTS)
         $display("%0t mismatch (%s): want word %h chan %b last %b, got word %h chan %b last %b",
                  $realtime, what, want.command_word, want.dest_channel, want.last_word,
                  got.command_word, got.dest_channel, got.last_word);
   endtask

   always @(posedge clock) begin : result_monitor
      rsp_type want;
      rsp_type words[$];
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            words_checked = words_checked + 1;
            if (expected_words.size() == 0) begin
               report_mismatch("no word owed", '0, rsp_data);
            end else begin
               want = expected_words.pop_front();
               if (rsp_data.command_word !== want.command_word)
                  report_mismatch("command_word", want, rsp_data);
               else if (rsp_data.dest_channel !== want.dest_channel)
                  report_mismatch("dest_channel", want, rsp_data);
               else if (rsp_data.last_word !== want.last_word)
                  report_mismatch("last_word", want, rsp_data);
            end
         end
         if (req_valid && !req_stall) begin
            build_setup_words(req_data, words);
            foreach (words[i])
               expected_words.push_back(words[i]);
            requests_taken = requests_taken + 1;
            if (req_data.action == ACT_DUAL)
               dual_taken = dual_taken + 1;
            if (req_data.wave_shape == SHAPE_NONE)
               no_ctrl_taken = no_ctrl_taken + 1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int unsigned n;
      // directed: field extremes, every shape, both modes, both registers,
      // out-of-range frequency and the shape code without a control word
      queue_request(make_request(27'd0, 1'b0, SHAPE_SINE, 12'h000, CHAN0, ACT_SINGLE), 0, 0);
      queue_request(make_request(27'd125000000, 1'b1, SHAPE_TRI, 12'hFFF, CHAN1, ACT_SINGLE),
                    0, 0);
      queue_request(make_request(27'h7FFFFFF, 1'b0, SHAPE_SQUARE, 12'hABC, CHAN0, ACT_SINGLE),
                    0, 0);
      queue_request(make_request(27'd1, 1'b1, SHAPE_NONE, 12'h555, CHAN1, ACT_SINGLE), 2, 0);
      queue_request(make_request(27'd10000000, 1'b0, SHAPE_SINE, 12'h000, CHAN0, ACT_DUAL),
                    0, 0);
      queue_request(make_request(27'h7FFFFFF, 1'b1, SHAPE_SQUARE, 12'hFFF, CHAN1, ACT_DUAL),
                    0, 0);
      queue_request(make_request(27'd123456789, 1'b0, SHAPE_NONE, 12'h0F0, CHAN0, ACT_DUAL),
                    5, 0);
      queue_request(make_request(27'd99, 1'b1, SHAPE_TRI, 12'h001, CHAN1, ACT_DUAL), 0, 0);
      queue_request(make_request(27'd125000001, 1'b0, SHAPE_TRI, 12'h800, CHAN1, ACT_SINGLE),
                    0, 0);
      queue_request(make_request(27'd100000000, 1'b1, SHAPE_NONE, 12'hFFF, CHAN0, ACT_SINGLE),
                    1, 0);
      queue_request(make_request(27'd15258, 1'b0, SHAPE_SQUARE, 12'h000, CHAN1, ACT_DUAL), 0, 0);
      queue_request(make_request(27'h4000000, 1'b1, SHAPE_SINE, 12'h7FF, CHAN0, ACT_DUAL), 0, 0);

      // random: an opening burst keeps the sender busy through the long
      // receiver hold-off; two requests wait for the block to drain first
      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         queue_request(random_request(), (n < 40) ? 0 : pick_sender_gap(), (n == 60 || n == 95));
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_words.size() != 0)
         @(posedge clock);
      // allow a margin for stray words
      repeat (20) @(posedge clock);

      $display("Ran %0d requests (%0d dual, %0d without a control word), %0d words checked.",
               requests_taken, dual_taken, no_ctrl_taken, words_checked);
      $display("Included a %0d-cycle result hold-off and a full drain pause; %0d mismatches.",
               LONG_HOLD_CYCLES, mismatches);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin : watchdog
      #3000000;
      $display("Timed out with %0d words still owed.", expected_words.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire
